[rtl/gsva_pkg.sv]
package gsva_pkg;

	localparam int MAX_VOICES    = 10;
	localparam int MAX_BLOCK     = 4096;
	localparam int MAX_REPORTED  = 63;
	localparam int FRAC_BITS     = 16;

	localparam int BLK_W   = 13;
	localparam int MASK_W  = 10;
	localparam int NV_W    = 4;
	localparam int VIDX_W  = $clog2(MAX_VOICES);
	localparam int SPAN_W  = BLK_W + FRAC_BITS;
	localparam int CD_W    = 33;
	localparam int AGE_W   = 32;
	localparam int DROP_W  = 16;
	localparam int REP_W   = $clog2(MAX_REPORTED + 1);
	localparam int CFG_W   = 32;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CFG_W-1:0] ONE_PERIOD = CFG_W'(64'd1 << FRAC_BITS);

	typedef enum logic [1:0] {
		KIND_FREE  = 2'd0,
		KIND_STEAL = 2'd1,
		KIND_SKIP  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_RATE_ON    = 2'd0,
		REG_PERIOD     = 2'd1,
		REG_GRAIN_EN   = 2'd2,
		REG_NUM_VOICES = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TEST,
		ST_SCAN,
		ST_STEAL,
		ST_DONE
	} eng_state_t;

	typedef struct packed {
		logic              rate_on;
		logic [CFG_W-1:0]  period;
		logic              grain_en;
		logic [NV_W-1:0]   num_voices;
	} cfg_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic [MASK_W-1:0] active;
	} job_t;

	function automatic logic [MASK_W-1:0] pool_mask(input logic [NV_W-1:0] nv);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int i = 0; i < MASK_W; i++) begin
			m[i] = (i < MAX_VOICES) && (i < int'(nv));
		end
		return m;
	endfunction

endpackage

[rtl/gsva_fifo.sv]
module gsva_fifo import gsva_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[rtl/gsva_front.sv]
module gsva_front import gsva_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BLK_W-1:0]  block_samples,
	input  logic [MASK_W-1:0] active_mask,
	input  cfg_t              cfg,
	input  logic              q_full,
	output logic              q_push,
	output job_t              q_job
);

	logic [BLK_W-1:0] blk;

	// Blocks longer than the limit are treated as the limit.
	assign blk = (block_samples > BLK_W'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : block_samples;

	assign in_stall      = q_full;
	assign q_push        = in_valid && !q_full;
	assign q_job.span    = {blk, {FRAC_BITS{1'b0}}};
	assign q_job.active  = active_mask & pool_mask(cfg.num_voices);

endmodule

[rtl/gsva_engine.sv]
module gsva_engine import gsva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              cfg_clear,
	input  logic              q_empty,
	input  job_t              q_job,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [VIDX_W-1:0] voice_index,
	output logic [AGE_W-1:0]  age_stamp,
	output logic [DROP_W-1:0] dropped_grains,
	output logic              last
);

	eng_state_t state_q, state_d;

	logic [CD_W-1:0]   countdown_q;
	logic [AGE_W-1:0]  next_age_q;
	logic [AGE_W-1:0]  age_q [MAX_VOICES];
	logic [MASK_W-1:0] active_q;
	logic [SPAN_W-1:0] span_q;
	logic [REP_W-1:0]  rep_q;
	logic [DROP_W-1:0] drop_q;
	logic [NV_W-1:0]   scan_q;
	logic [VIDX_W-1:0] best_idx_q;
	logic [AGE_W-1:0]  best_age_q;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [VIDX_W-1:0] voice_q;
	logic [AGE_W-1:0]  stamp_q;
	logic [DROP_W-1:0] dropped_q;
	logic              last_q;

	logic [MASK_W-1:0] pmask;
	logic [MASK_W-1:0] free_mask;
	logic              has_free;
	logic [VIDX_W-1:0] free_idx;
	logic              due;
	logic              skip;
	logic              out_free;
	logic              cap_hit;
	logic              slot_ok;

	logic              fire;
	kind_t             fire_kind;
	logic [VIDX_W-1:0] fire_voice;
	logic              take_voice;
	logic              scan_start;
	logic              scan_step;
	logic              settle;
	logic              load_out;
	logic              load_done;

	assign pmask     = pool_mask(cfg.num_voices);
	assign free_mask = ~active_q & pmask;
	assign due       = countdown_q < CD_W'(span_q);
	assign skip      = !cfg.grain_en || (cfg.num_voices == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign cap_hit   = (rep_q == REP_W'(MAX_REPORTED));
	// Grains past the report cap need no output slot.
	assign slot_ok   = cap_hit || out_free;

	always_comb begin
		has_free = 1'b0;
		free_idx = '0;
		for (int i = MAX_VOICES - 1; i >= 0; i--) begin
			if (free_mask[i]) begin
				has_free = 1'b1;
				free_idx = VIDX_W'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) state_d = ST_TEST;
			end
			ST_TEST: begin
				if (!cfg.rate_on || !due) begin
					state_d = ST_DONE;
				end else if (!skip && !has_free) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == cfg.num_voices) state_d = ST_STEAL;
			end
			ST_STEAL: begin
				if (slot_ok) state_d = ST_TEST;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		fire       = 1'b0;
		fire_kind  = KIND_SKIP;
		fire_voice = '0;
		scan_start = 1'b0;
		scan_step  = 1'b0;
		settle     = 1'b0;
		load_done  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_pop = !q_empty;
			end
			ST_TEST: begin
				if (cfg.rate_on && due) begin
					if (skip) begin
						fire      = slot_ok;
						fire_kind = KIND_SKIP;
					end else if (has_free) begin
						fire       = slot_ok;
						fire_kind  = KIND_FREE;
						fire_voice = free_idx;
					end else begin
						scan_start = 1'b1;
					end
				end else if (cfg.rate_on) begin
					settle = 1'b1;
				end
			end
			ST_SCAN: begin
				scan_step = (scan_q != cfg.num_voices);
			end
			ST_STEAL: begin
				fire       = slot_ok;
				fire_kind  = KIND_STEAL;
				fire_voice = best_idx_q;
			end
			ST_DONE: begin
				load_done = out_free;
			end
			default: ;
		endcase
	end

	assign take_voice = fire && (fire_kind != KIND_SKIP);
	assign load_out   = (fire && !cap_hit) || load_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			countdown_q <= '0;
			next_age_q  <= '0;
			for (int i = 0; i < MAX_VOICES; i++) age_q[i] <= '0;
			active_q    <= '0;
			rep_q       <= '0;
			drop_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_clear) begin
				countdown_q <= '0;
				for (int i = 0; i < MAX_VOICES; i++) age_q[i] <= '0;
			end
			if (q_pop) begin
				active_q <= q_job.active;
				rep_q    <= '0;
				drop_q   <= '0;
			end
			if (fire) begin
				countdown_q <= countdown_q + CD_W'(cfg.period);
				if (!cap_hit) begin
					rep_q <= rep_q + REP_W'(1);
				end else if (drop_q != '1) begin
					drop_q <= drop_q + DROP_W'(1);
				end
			end
			if (take_voice) begin
				active_q[fire_voice] <= 1'b1;
				age_q[fire_voice]    <= next_age_q;
				next_age_q           <= next_age_q + AGE_W'(1);
			end
			if (scan_start) begin
				scan_q <= NV_W'(1);
			end else if (scan_step) begin
				scan_q <= scan_q + NV_W'(1);
			end
			// On leaving the grain loop the countdown is never below the span.
			if (settle) begin
				countdown_q <= countdown_q - CD_W'(span_q);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			span_q <= q_job.span;
		end
		if (scan_start) begin
			best_idx_q <= '0;
			best_age_q <= age_q[0];
		end else if (scan_step) begin
			if (age_q[scan_q[VIDX_W-1:0]] < best_age_q) begin
				best_idx_q <= scan_q[VIDX_W-1:0];
				best_age_q <= age_q[scan_q[VIDX_W-1:0]];
			end
		end
		if (load_out) begin
			if (load_done) begin
				kind_q    <= KIND_DONE;
				voice_q   <= '0;
				stamp_q   <= '0;
				dropped_q <= drop_q;
				last_q    <= 1'b1;
			end else begin
				kind_q    <= fire_kind;
				voice_q   <= take_voice ? fire_voice : '0;
				stamp_q   <= take_voice ? next_age_q : '0;
				dropped_q <= '0;
				last_q    <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign voice_index    = voice_q;
	assign age_stamp      = stamp_q;
	assign dropped_grains = dropped_q;
	assign last           = last_q;

	// A steal search only starts once every voice in the pool is sounding.
	a_scan_pool_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((active_q & pmask) == pmask))
		else $error("steal search with a free voice in the pool");

	a_rep_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rep_q <= REP_W'(MAX_REPORTED))
		else $error("reported grain count beyond cap");

	a_age_step: assert property (@(posedge clk) disable iff (!arst_n)
		take_voice |=> (next_age_q == $past(next_age_q) + AGE_W'(1)))
		else $error("age stamp did not advance after a trigger");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (kind_q == KIND_DONE))
		else $error("last flag on a grain word");

endmodule

[rtl/grain_scheduler_voice_allocator_top.sv]
// Channel   Handshake            Payload
// in        in_valid / in_stall  block_samples, active_mask
// out       out_valid/ out_stall kind, voice_index, age_stamp, dropped_grains, last
// cfg       cfg_we               cfg_index, cfg_data
//
// Each grain that steals the oldest voice first runs a steal search over the pool;
// the steal search reads one age a cycle.
// A two-word queue lets the next block be taken while the engine is still busy.
// Reset clears the countdown, the age stamps and the voice flags, and sets the registers to their defaults.
// A stalled output holds its word; the engine waits only when it has a word to report
// and the word already held is stalled.
module grain_scheduler_voice_allocator_top import gsva_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BLK_W-1:0]  block_samples,
	input  logic [MASK_W-1:0] active_mask,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [VIDX_W-1:0] voice_index,
	output logic [AGE_W-1:0]  age_stamp,
	output logic [DROP_W-1:0] dropped_grains,
	output logic              last
);

	logic             rate_on_q;
	logic [CFG_W-1:0] period_q;
	logic             grain_en_q;
	logic [NV_W-1:0]  num_voices_q;
	logic             cfg_clear;
	logic             nv_ok;
	cfg_t             cfg;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	job_t push_job;
	job_t pop_job;

	// A pool size above the limit is refused and leaves everything untouched.
	assign nv_ok = (cfg_data[NV_W-1:0] <= NV_W'(MAX_VOICES));

	always_comb begin
		cfg_clear = 1'b0;
		if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RATE_ON:    cfg_clear = 1'b1;
				REG_PERIOD:     cfg_clear = 1'b1;
				REG_GRAIN_EN:   cfg_clear = 1'b1;
				REG_NUM_VOICES: cfg_clear = nv_ok;
				default:        cfg_clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_on_q    <= 1'b0;
			period_q     <= ONE_PERIOD;
			grain_en_q   <= 1'b0;
			num_voices_q <= NV_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RATE_ON:    rate_on_q <= cfg_data[0];
				// Periods shorter than one sample are stored as one sample.
				REG_PERIOD:     period_q <= (cfg_data < ONE_PERIOD) ? ONE_PERIOD : cfg_data;
				REG_GRAIN_EN:   grain_en_q <= cfg_data[0];
				REG_NUM_VOICES: begin
					if (nv_ok) num_voices_q <= cfg_data[NV_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign cfg.rate_on    = rate_on_q;
	assign cfg.period     = period_q;
	assign cfg.grain_en   = grain_en_q;
	assign cfg.num_voices = num_voices_q;

	gsva_front u_front (
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.block_samples (block_samples),
		.active_mask   (active_mask),
		.cfg           (cfg),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (push_job)
	);

	gsva_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	gsva_engine u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cfg_clear      (cfg_clear),
		.q_empty        (q_empty),
		.q_job          (pop_job),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.voice_index    (voice_index),
		.age_stamp      (age_stamp),
		.dropped_grains (dropped_grains),
		.last           (last)
	);

endmodule

[test/tb_top.sv]
module tb_top;
	import gsva_pkg::*;

	typedef struct {
		kind_t               kind;
		logic [VIDX_W-1:0]   voice;
		logic [AGE_W-1:0]    stamp;
		logic [DROP_W-1:0]   dropped;
		logic                last;
	} grain_word_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [BLK_W-1:0]  block_samples = '0;
	logic [MASK_W-1:0] active_mask = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        kind;
	logic [VIDX_W-1:0] voice_index;
	logic [AGE_W-1:0]  age_stamp;
	logic [DROP_W-1:0] dropped_grains;
	logic              last;

	// Scheduler state as the testbench sees it.
	logic [CD_W-1:0]   p_countdown = '0;
	logic [AGE_W-1:0]  p_next_age = '0;
	logic [AGE_W-1:0]  p_age [MAX_VOICES];
	logic [MASK_W-1:0] p_busy = '0;
	logic              p_rate_on = 1'b0;
	logic [CFG_W-1:0]  p_period = ONE_PERIOD;
	logic              p_grain_en = 1'b0;
	logic [NV_W-1:0]   p_voices = 4'd1;

	grain_word_t pending_words [$];
	grain_word_t head_word;

	bit in_idle = 1'b0;
	bit out_idle = 1'b0;
	int hold_off_cycles = 0;
	int mismatches = 0;
	int blocks_sent = 0;
	int words_checked = 0;
	int reg_writes = 0;
	int n_free = 0;
	int n_stolen = 0;
	int n_skipped = 0;
	int n_capped = 0;

	grain_scheduler_voice_allocator_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.block_samples  (block_samples),
		.active_mask    (active_mask),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.voice_index    (voice_index),
		.age_stamp      (age_stamp),
		.dropped_grains (dropped_grains),
		.last           (last)
	);

	always #2 clk = ~clk;

	initial begin
		foreach (p_age[i]) p_age[i] = '0;
	end

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	function automatic void apply_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		case (idx)
			REG_RATE_ON: begin
				p_rate_on = val[0];
			end
			REG_PERIOD: begin
				p_period = val;
			end
			REG_GRAIN_EN: begin
				p_grain_en = val[0];
			end
			REG_NUM_VOICES: begin
				// An oversized pool is refused outright and clears nothing.
				if (val[NV_W-1:0] > MAX_VOICES) return;
				p_voices = val[NV_W-1:0];
			end
		endcase
		foreach (p_age[i]) p_age[i] = '0;
		p_countdown = '0;
	endfunction

	// Works out the grain words and the closing word of one audio block.
	function automatic void schedule_block(input logic [BLK_W-1:0] blk_in,
			input logic [MASK_W-1:0] mask);
		logic [BLK_W-1:0]  blk;
		logic [MASK_W:0]   pool;
		logic [CD_W-1:0]   span;
		logic [CD_W-1:0]   period;
		logic [DROP_W-1:0] dropped;
		logic [VIDX_W-1:0] pick;
		logic              found;
		int                reported;
		grain_word_t       w;
		blk = (blk_in > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : blk_in;
		pool = ({{MASK_W{1'b0}}, 1'b1} << p_voices) - 1'b1;
		p_busy = mask & pool[MASK_W-1:0];
		dropped = '0;
		reported = 0;
		if (p_rate_on) begin
			span = CD_W'(blk) << FRAC_BITS;
			period = (p_period < ONE_PERIOD) ? CD_W'(ONE_PERIOD) : CD_W'(p_period);
			while (p_countdown < span) begin
				w.kind = KIND_SKIP;
				w.voice = '0;
				w.stamp = '0;
				w.dropped = '0;
				w.last = 1'b0;
				if (p_grain_en && p_voices != 0) begin
					found = 1'b0;
					pick = '0;
					for (int i = 0; i < MAX_VOICES; i++) begin
						if (!found && i < p_voices && !p_busy[i]) begin
							found = 1'b1;
							pick = VIDX_W'(i);
						end
					end
					w.kind = KIND_FREE;
					if (!found) begin
						// Every voice in the pool is sounding: take the oldest,
						// and the lowest index when stamps are equal.
						w.kind = KIND_STEAL;
						for (int i = 0; i < MAX_VOICES; i++) begin
							if (i < p_voices && (!found || p_age[i] < p_age[pick])) begin
								found = 1'b1;
								pick = VIDX_W'(i);
							end
						end
					end
					p_busy[pick] = 1'b1;
					p_age[pick] = p_next_age;
					w.voice = pick;
					w.stamp = p_next_age;
					p_next_age = p_next_age + 1'b1;
				end
				if (reported < MAX_REPORTED) begin
					pending_words.push_back(w);
					reported++;
				end else if (dropped != '1) begin
					dropped = dropped + 1'b1;
				end
				p_countdown = p_countdown + period;
			end
			p_countdown = (p_countdown > span) ? p_countdown - span : '0;
		end
		w.kind = KIND_DONE;
		w.voice = '0;
		w.stamp = '0;
		w.dropped = dropped;
		w.last = 1'b1;
		pending_words.push_back(w);
	endfunction

	task automatic send_block(input logic [BLK_W-1:0] blk, input logic [MASK_W-1:0] mask);
		int gap;
		in_valid <= 1'b1;
		block_samples <= blk;
		active_mask <= mask;
		do @(posedge clk); while (in_stall);
		schedule_block(blk, mask);
		blocks_sent++;
		@(negedge clk);
		gap = in_idle ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_random_block();
		logic [BLK_W-1:0]  blk;
		logic [MASK_W-1:0] mask;
		case ($urandom_range(0, 49))
			0: blk = BLK_W'($urandom_range(0, 8191));
			1, 2, 3: blk = BLK_W'($urandom_range(0, 15));
			default: blk = BLK_W'($urandom_range(16, 400));
		endcase
		mask = ($urandom_range(0, 2) == 0) ? '1 : MASK_W'($urandom);
		send_block(blk, mask);
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until the block has reported everything it was given.
	task automatic wait_idle();
		release_input();
		while (pending_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic set_config(input logic rate, input logic [CFG_W-1:0] period,
			input logic gen, input logic [NV_W-1:0] nv);
		logic [CFG_W-1:0] junk;
		wait_idle();
		junk = $urandom;
		write_reg(REG_RATE_ON, {junk[CFG_W-1:1], rate});
		write_reg(REG_PERIOD, period);
		junk = $urandom;
		write_reg(REG_GRAIN_EN, {junk[CFG_W-1:1], gen});
		junk = $urandom;
		write_reg(REG_NUM_VOICES, {junk[CFG_W-1:NV_W], nv});
	endtask

	task automatic test_scheduling_off();
		send_block('0, '0);
		send_block('1, '1);
		send_block(BLK_W'(4096), 10'h155);
	endtask

	task automatic test_free_and_steal();
		in_idle = 1'b1;
		out_idle = 1'b1;
		set_config(1'b1, 32'd16 << FRAC_BITS, 1'b1, 4'd10);
		send_block(BLK_W'(64), '0);
		send_block(BLK_W'(160), '1);
		send_block(BLK_W'(160), 10'h2AA);
		send_block('0, '1);
		set_config(1'b1, 32'd16 << FRAC_BITS, 1'b1, 4'd1);
		send_block(BLK_W'(48), 10'h001);
	endtask

	task automatic test_report_cap();
		// A period below one sample behaves as one sample, so the longest
		// block gives more grains than can be reported.
		set_config(1'b1, '0, 1'b1, 4'd3);
		send_block(BLK_W'(4096), 10'h007);
		set_config(1'b1, 32'h0000_FFFF, 1'b1, 4'd3);
		send_block('1, '0);
		set_config(1'b1, ONE_PERIOD, 1'b1, 4'd3);
		send_block('0, '0);
		send_block(BLK_W'(1), '0);
	endtask

	task automatic test_skipped_grains();
		set_config(1'b1, 32'd10 << FRAC_BITS, 1'b0, 4'd10);
		send_block(BLK_W'(100), '1);
		set_config(1'b1, 32'd10 << FRAC_BITS, 1'b1, 4'd0);
		send_block(BLK_W'(100), '1);
	endtask

	task automatic test_pool_writes();
		set_config(1'b1, 32'd10 << FRAC_BITS, 1'b1, 4'd10);
		send_block(BLK_W'(50), '0);
		wait_idle();
		// Pool sizes above the maximum are refused, so ages and the countdown stay.
		write_reg(REG_NUM_VOICES, 32'hFFFF_FFFF);
		send_block(BLK_W'(50), '1);
		wait_idle();
		write_reg(REG_NUM_VOICES, 32'h0000_000B);
		write_reg(REG_NUM_VOICES, 32'hFFFF_FFF5);
		send_block(BLK_W'(50), 10'h3E0);
	endtask

	task automatic test_long_period();
		set_config(1'b1, 32'hFFFF_FFFF, 1'b1, 4'd10);
		send_block(BLK_W'(4096), '0);
		send_block(BLK_W'(4096), '0);
		send_block(BLK_W'(100), '0);
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 32'd8 << FRAC_BITS, 1'b1, 4'd10);
		in_idle = 1'b0;
		out_idle = 1'b0;
		hold_off_cycles = 400;
		repeat (10) send_random_block();
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] period;
		logic [NV_W-1:0]  nv;
		for (int phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 7))
				0: period = CFG_W'($urandom_range(0, 65535));
				1: period = $urandom;
				2: period = '1;
				default: period = CFG_W'($urandom_range(32'd1 << 16, 32'd48 << 16));
			endcase
			nv = ($urandom_range(0, 7) == 0) ? NV_W'($urandom_range(11, 15))
				: NV_W'($urandom_range(0, MAX_VOICES));
			set_config($urandom_range(0, 7) != 0, period, $urandom_range(0, 5) != 0, nv);
			in_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
			out_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
			repeat (40) send_random_block();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				note_mismatch($sformatf("word with nothing expected: kind %0d voice %0d stamp %0d",
					kind, voice_index, age_stamp));
			end else begin
				head_word = pending_words.pop_front();
				words_checked++;
				if (kind !== head_word.kind)
					note_mismatch($sformatf("kind %0d, expected %0d", kind, head_word.kind));
				if (voice_index !== head_word.voice)
					note_mismatch($sformatf("voice_index %0d, expected %0d",
						voice_index, head_word.voice));
				if (age_stamp !== head_word.stamp)
					note_mismatch($sformatf("age_stamp %0d, expected %0d",
						age_stamp, head_word.stamp));
				if (dropped_grains !== head_word.dropped)
					note_mismatch($sformatf("dropped_grains %0d, expected %0d",
						dropped_grains, head_word.dropped));
				if (last !== head_word.last)
					note_mismatch($sformatf("last %0b, expected %0b", last, head_word.last));
				case (head_word.kind)
					KIND_FREE: n_free++;
					KIND_STEAL: n_stolen++;
					KIND_SKIP: n_skipped++;
					KIND_DONE: if (head_word.dropped != 0) n_capped++;
				endcase
			end
		end
	end

	// Output side: a random pause before each word while out_idle is set, plus any long hold-off requested.
	initial begin : receiver
		int wait_cycles;
		forever begin
			@(negedge clk);
			wait_cycles = out_idle ? $urandom_range(0, 12) : 0;
			wait_cycles += hold_off_cycles;
			hold_off_cycles = 0;
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#400000000;
		$display("Timed out with %0d words still expected", pending_words.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_scheduling_off();
		test_free_and_steal();
		test_report_cap();
		test_skipped_grains();
		test_pool_writes();
		test_long_period();
		test_backpressure();
		test_random_phases();
		wait_idle();
		repeat (20) @(negedge clk);
		$display("Sent %0d audio blocks and checked %0d words after %0d register writes.",
			blocks_sent, words_checked, reg_writes);
		$display("Voices taken free %0d, stolen %0d, grains skipped %0d, blocks over cap %0d.",
			n_free, n_stolen, n_skipped, n_capped);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
